// ===== hdl/tla_pkg.sv =====
// Shared constants, types and position codes for the text line annotator.
package tla_pkg;

    localparam int NUMBER_DIGITS = 6;
    // The counter stops at 999999, so no more than six digits ever count.
    localparam int SAT_DIGITS    = (NUMBER_DIGITS < 6) ? NUMBER_DIGITS : 6;
    localparam int POS_W         = $clog2(NUMBER_DIGITS + 4);
    // Must be a power of two so that the pointers wrap on their own.
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 8;

    localparam logic [7:0] CH_NL       = 8'd10;
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] CH_DOLLAR   = 8'd36;
    localparam logic [7:0] CH_CARET    = 8'd94;
    localparam logic [7:0] CARET_SHIFT = 8'd64;
    localparam logic [7:0] CTRL_MAX    = 8'd31;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_ALL       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    // Output positions within one item's burst; digits take 0 .. NUMBER_DIGITS-1.
    localparam logic [POS_W-1:0] POS_TAB    = POS_W'(NUMBER_DIGITS);
    localparam logic [POS_W-1:0] POS_DOLLAR = POS_W'(NUMBER_DIGITS + 1);
    localparam logic [POS_W-1:0] POS_CARET  = POS_W'(NUMBER_DIGITS + 2);
    localparam logic [POS_W-1:0] POS_DATA   = POS_W'(NUMBER_DIGITS + 3);

    typedef logic [3:0] t_bcd;
    typedef t_bcd [NUMBER_DIGITS-1:0] t_count;

    localparam t_count COUNT_ONE = t_count'(1);

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    typedef struct packed {
        logic             number;
        logic             dollar;
        logic             caret;
        logic [7:0]       data;
        t_count           digits;
        logic [POS_W-1:0] start_pos;
    } t_job;

endpackage

// ===== hdl/tla_if.sv =====
// Handshake channel interfaces for the input, output and configuration ports.
interface tla_in_if ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_start;

    modport source (output valid, output in_byte, output file_start, input ready);
    modport sink (input valid, input in_byte, input file_start, output ready);
endinterface

interface tla_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface tla_cfg_if import tla_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/text_line_annotator.sv =====
// Top level of the text line annotator: configuration registers, front end, job queue, back end.
// Input items are taken one per clock while the four-entry job queue has room, and every
// output channel cycle can carry one byte. An item gives between one and NUMBER_DIGITS + 3
// output bytes (up to nine at a numbered line start), or none when a blank line is squeezed;
// the back end emits one byte per clock while the output is ready, so the sustained rate is set
// by the number of bytes each item expands into, and a line-start burst holds the input only
// once the queue fills. With the queue empty, an accepted item is written into the queue and
// its first byte is then registered into the output register. Configuration writes are always
// ready and should be made while no item is in flight. No clearing pass follows reset; the
// block is ready as soon as reset is released.
module text_line_annotator import tla_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tla_in_if.sink     i_in,
    tla_out_if.source  o_out,
    tla_cfg_if.sink    i_cfg
);

    t_cfg r_cfg;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_job q_job;
    t_job q_head;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg.data[0];
                CFG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg.data[0];
                CFG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg.data[0];
                CFG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg.data[0];
                CFG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg.data[0];
                CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg.data[0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    tla_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (q_job)
    );

    tla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    tla_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== hdl/tla_front.sv =====
// Front end: accepts input items, tracks line state and the BCD line counter, builds jobs.
module tla_front import tla_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    tla_in_if.sink i_in,
    input  logic   i_q_full,
    output logic   o_push,
    output t_job   o_job
);

    logic   r_prior_nl;
    logic   r_blank_run;
    t_count r_count;
    logic   n_prior_nl;
    logic   n_blank_run;
    t_count n_count;

    logic       accept;
    logic [7:0] c;
    logic       is_nl;
    logic       is_tab;
    logic       eff_prior_nl;
    logic       eff_blank;
    t_count     eff_count;
    logic       squeeze;
    logic       do_number;
    logic       dollar;
    logic       caret;
    logic       sat;
    t_count     count_inc;

    function automatic t_count bcd_step(input t_count v);
        t_count r;
        logic   carry;
        r = v;
        carry = 1'b1;
        for (int k = 0; k < NUMBER_DIGITS; k++) begin
            if (carry) begin
                if (r[k] == 4'd9) begin
                    r[k] = 4'd0;
                end else begin
                    r[k] = r[k] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign c          = i_in.in_byte;
    assign is_nl      = (c == CH_NL);
    assign is_tab     = (c == CH_TAB);

    // A file start rewinds the line state before this item is looked at.
    assign eff_prior_nl = i_in.file_start | r_prior_nl;
    assign eff_blank    = !i_in.file_start & r_blank_run;
    assign eff_count    = i_in.file_start ? COUNT_ONE : r_count;

    assign squeeze   = i_cfg.squeeze_blank && eff_prior_nl && is_nl && eff_blank;
    assign do_number = eff_prior_nl &&
                       ((i_cfg.number_all && !i_cfg.number_nonblank) ||
                        (i_cfg.number_nonblank && !is_nl));
    assign dollar    = is_nl && i_cfg.show_ends;
    // A tab is either shown by the tab option or left alone; newline is never shifted.
    assign caret     = is_tab ? i_cfg.show_tabs
                              : (i_cfg.show_nonprinting && (c <= CTRL_MAX) && !is_nl);

    always_comb begin
        sat = 1'b1;
        for (int k = 0; k < SAT_DIGITS; k++) begin
            sat = sat && (eff_count[k] == 4'd9);
        end
    end

    assign count_inc = bcd_step(eff_count);

    always_comb begin
        o_job.number = do_number;
        o_job.dollar = dollar;
        o_job.caret  = caret;
        o_job.data   = caret ? (c + CARET_SHIFT) : c;
        o_job.digits = eff_count;
        if (do_number) begin
            o_job.start_pos = '0;
        end else if (dollar) begin
            o_job.start_pos = POS_DOLLAR;
        end else if (caret) begin
            o_job.start_pos = POS_CARET;
        end else begin
            o_job.start_pos = POS_DATA;
        end
    end

    assign o_push = accept && !squeeze;

    always_comb begin
        n_prior_nl  = r_prior_nl;
        n_blank_run = r_blank_run;
        n_count     = r_count;
        if (accept) begin
            if (squeeze) begin
                n_prior_nl  = eff_prior_nl;
                n_blank_run = eff_blank;
                n_count     = eff_count;
            end else begin
                n_prior_nl  = is_nl;
                n_blank_run = eff_prior_nl && is_nl;
                n_count     = (do_number && !sat) ? count_inc : eff_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_nl  <= 1'b1;
            r_blank_run <= 1'b0;
            r_count     <= COUNT_ONE;
        end else begin
            r_prior_nl  <= n_prior_nl;
            r_blank_run <= n_blank_run;
            r_count     <= n_count;
        end
    end

endmodule

// ===== hdl/tla_queue.sv =====
// Short job queue between the front end and the output sequencer.
module tla_queue import tla_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_fill;

    assign o_full  = (r_fill == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ===== hdl/tla_back.sv =====
// Back end: expands the head job into the output register, a byte per cycle unless stalled.
module tla_back import tla_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_head,
    output logic       o_pop,
    tla_out_if.source  o_out
);

    logic             r_mid;
    logic [POS_W-1:0] r_pos;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic [POS_W-1:0] cur_pos;
    logic [POS_W-1:0] nxt_pos;
    logic [7:0]       digit_byte [NUMBER_DIGITS];
    logic [7:0]       sel_byte;
    logic             is_last;
    logic             advance;
    logic             zero_run;

    assign cur_pos = r_mid ? r_pos : i_head.start_pos;
    assign is_last = (cur_pos == POS_DATA);
    assign advance = !r_out_valid || o_out.ready;
    assign o_pop   = advance && i_q_valid && is_last;

    // Leading zeros of the number print as spaces; the units digit always prints.
    always_comb begin
        zero_run = 1'b1;
        for (int p = 0; p < NUMBER_DIGITS; p++) begin
            zero_run = zero_run && (i_head.digits[NUMBER_DIGITS-1-p] == 4'd0);
            if (zero_run && (p != NUMBER_DIGITS - 1)) begin
                digit_byte[p] = CH_SPACE;
            end else begin
                digit_byte[p] = CH_ZERO + {4'd0, i_head.digits[NUMBER_DIGITS-1-p]};
            end
        end
    end

    always_comb begin
        sel_byte = i_head.data;
        for (int k = 0; k < NUMBER_DIGITS; k++) begin
            if (cur_pos == POS_W'(k)) begin
                sel_byte = digit_byte[k];
            end
        end
        if (cur_pos == POS_TAB) begin
            sel_byte = CH_TAB;
        end else if (cur_pos == POS_DOLLAR) begin
            sel_byte = CH_DOLLAR;
        end else if (cur_pos == POS_CARET) begin
            sel_byte = CH_CARET;
        end
    end

    always_comb begin
        if (cur_pos == POS_TAB) begin
            if (i_head.dollar) begin
                nxt_pos = POS_DOLLAR;
            end else if (i_head.caret) begin
                nxt_pos = POS_CARET;
            end else begin
                nxt_pos = POS_DATA;
            end
        end else if ((cur_pos == POS_DOLLAR) || (cur_pos == POS_CARET)) begin
            nxt_pos = POS_DATA;
        end else begin
            nxt_pos = cur_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_out_last  <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_q_valid;
            if (i_q_valid) begin
                r_out_byte <= sel_byte;
                r_out_last <= is_last;
                r_mid      <= !is_last;
                r_pos      <= nxt_pos;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;

endmodule

// ===== hdl/tla_checker.sv =====
// Port-level checks on the output channel of the text line annotator, bound to the top level.
module tla_checker import tla_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("stalled output item changed");

    // A caret prefix is followed at once by its shifted data byte.
    a_caret_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last && (i_out_byte == CH_CARET) |=>
            i_out_valid && i_out_last)
        else $error("caret prefix not followed by data byte");

    // An end marker is followed at once by the newline that closes the item.
    a_dollar_then_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last && (i_out_byte == CH_DOLLAR) |=>
            i_out_valid && i_out_last && (i_out_byte == CH_NL))
        else $error("end marker not followed by newline");

endmodule

bind text_line_annotator tla_checker u_tla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last_of_run)
);
